>>> src/urb_pkg.sv
// Package for the ultrasonic range buzzer: register map, status and band codes,
// reset values and the structs shared by the top level and the core.
// No dependencies.
package urb_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;
    localparam int DIST_BITS      = 10;
    localparam int WIDTH_BITS     = 15;
    localparam int LIMIT_BITS     = 10;
    localparam int PERIOD_BITS    = 20;
    localparam int MUL_BITS       = 11;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FAR_LIMIT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MID_LIMIT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEAR_LIMIT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOW_HALF    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST_HALF    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RISE_TIMEOUT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ECHO_LIMIT   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CYCLE_GAP    = 3'd7;

    // Measurement status codes
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT     = 2'd1;
    localparam logic [1:0] STAT_NO_OBSTACLE = 2'd2;

    // Buzzer bands
    localparam logic [1:0] BAND_OFF    = 2'd0;
    localparam logic [1:0] BAND_SLOW   = 2'd1;
    localparam logic [1:0] BAND_FAST   = 2'd2;
    localparam logic [1:0] BAND_STEADY = 2'd3;

    // Fixed point cm per microsecond of echo: 0.0343 / 2 * 2^16
    localparam logic [MUL_BITS-1:0]   DIST_MUL  = 11'd1124;
    localparam logic [DIST_BITS-1:0]  DIST_MAX  = 10'd1023;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = 15'h7fff;

    // Register reset values
    localparam logic [LIMIT_BITS-1:0]  RST_FAR_LIMIT    = 10'd20;
    localparam logic [LIMIT_BITS-1:0]  RST_MID_LIMIT    = 10'd15;
    localparam logic [LIMIT_BITS-1:0]  RST_NEAR_LIMIT   = 10'd10;
    localparam logic [PERIOD_BITS-1:0] RST_SLOW_HALF    = 20'd750000;
    localparam logic [PERIOD_BITS-1:0] RST_FAST_HALF    = 20'd300000;
    localparam logic [PERIOD_BITS-1:0] RST_RISE_TIMEOUT = 20'd600000;
    localparam logic [WIDTH_BITS-1:0]  RST_ECHO_LIMIT   = 15'd30000;
    localparam logic [PERIOD_BITS-1:0] RST_CYCLE_GAP    = 20'd0;

    typedef struct packed {
        logic [LIMIT_BITS-1:0]  far_limit;
        logic [LIMIT_BITS-1:0]  mid_limit;
        logic [LIMIT_BITS-1:0]  near_limit;
        logic [PERIOD_BITS-1:0] slow_half;
        logic [PERIOD_BITS-1:0] fast_half;
        logic [PERIOD_BITS-1:0] rise_timeout;
        logic [WIDTH_BITS-1:0]  echo_limit;
        logic [PERIOD_BITS-1:0] cycle_gap;
    } t_cfg;

    typedef struct packed {
        logic                 trigger;
        logic                 buzzer;
        logic                 done;
        logic [1:0]           status;
        logic [DIST_BITS-1:0] distance;
    } t_result;

endpackage

>>> src/urb_core.sv
// Measurement sequencer of the ultrasonic range buzzer: phase state, timers,
// echo width, distance conversion, band choice and the registered tick result.
// Depends on urb_pkg.
module urb_core #(
    parameter int TIMER_BITS         = 20,
    parameter int TRIGGER_HIGH_TICKS = 10,
    parameter int TRIGGER_LOW_TICKS  = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_echo_level,
    input  urb_pkg::t_cfg   i_cfg,
    output urb_pkg::t_result o_result
);
    import urb_pkg::*;

    localparam int CMP_BITS = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_TRIG_LOW  = 3'd0,
        PH_TRIG_HIGH = 3'd1,
        PH_WAIT_RISE = 3'd2,
        PH_MEASURE   = 3'd3,
        PH_BLINK_ON  = 3'd4,
        PH_BLINK_OFF = 3'd5,
        PH_GAP       = 3'd6
    } t_phase;

    t_phase                  r_phase, n_phase, eff_phase, fin_phase, after_buzz;
    logic [TIMER_BITS-1:0]   r_timer, n_timer, eff_timer, timer_inc;
    logic [WIDTH_BITS-1:0]   r_width, n_width;
    logic [DIST_BITS-1:0]    r_dist, n_dist, fin_dist, calc_dist;
    logic [1:0]              r_status, n_status, fin_status, meas_status;
    logic [1:0]              r_band, n_band, fin_band, calc_band;
    logic [CMP_BITS-1:0]     phase_len;
    logic                    expired;
    logic [PERIOD_BITS-1:0]  half;
    logic [WIDTH_BITS+MUL_BITS-1:0] product;
    t_result                 r_result, n_result;

    // Distance and band of the current echo width
    always_comb begin
        product   = (WIDTH_BITS+MUL_BITS)'(r_width) * (WIDTH_BITS+MUL_BITS)'(DIST_MUL);
        calc_dist = product[WIDTH_BITS+MUL_BITS-1:16];
        if (calc_dist > i_cfg.far_limit) begin
            calc_band = BAND_OFF;
        end else if (calc_dist > i_cfg.mid_limit) begin
            calc_band = BAND_SLOW;
        end else if (calc_dist > i_cfg.near_limit) begin
            calc_band = BAND_FAST;
        end else begin
            calc_band = BAND_STEADY;
        end
    end

    always_comb begin
        // an unused phase code restarts as a fresh trigger low phase
        if (r_phase > PH_GAP) begin
            eff_phase = PH_TRIG_LOW;
            eff_timer = '0;
        end else begin
            eff_phase = r_phase;
            eff_timer = r_timer;
        end

        half = (r_band == BAND_SLOW) ? i_cfg.slow_half : i_cfg.fast_half;

        case (eff_phase)
            PH_TRIG_LOW:  phase_len = CMP_BITS'(TRIGGER_LOW_TICKS);
            PH_TRIG_HIGH: phase_len = CMP_BITS'(TRIGGER_HIGH_TICKS);
            PH_WAIT_RISE: phase_len = CMP_BITS'(i_cfg.rise_timeout);
            PH_BLINK_ON,
            PH_BLINK_OFF: phase_len = CMP_BITS'(half);
            default:      phase_len = CMP_BITS'(i_cfg.cycle_gap);
        endcase

        // saturating timer; reaching the top also ends the phase
        timer_inc = (eff_timer == TIMER_MAX) ? eff_timer : eff_timer + 1'b1;
        expired   = (CMP_BITS'(timer_inc) >= phase_len) || (timer_inc == TIMER_MAX);

        // measurement end: status, distance, band and following phase
        if (i_echo_level) begin
            meas_status = STAT_NO_OBSTACLE;
        end else if (r_width > i_cfg.echo_limit) begin
            meas_status = STAT_NO_OBSTACLE;
        end else begin
            meas_status = STAT_OK;
        end
        fin_status = (eff_phase == PH_WAIT_RISE) ? STAT_TIMEOUT : meas_status;
        fin_dist   = (fin_status == STAT_OK) ? calc_dist : DIST_MAX;
        fin_band   = (fin_status == STAT_OK) ? calc_band : BAND_OFF;
        after_buzz = (i_cfg.cycle_gap == '0) ? PH_TRIG_LOW : PH_GAP;
        fin_phase  = (fin_band == BAND_SLOW || fin_band == BAND_FAST) ? PH_BLINK_ON
                                                                       : after_buzz;

        n_phase  = eff_phase;
        n_timer  = eff_timer;
        n_width  = r_width;
        n_dist   = r_dist;
        n_status = r_status;
        n_band   = r_band;
        n_result.trigger = 1'b0;
        n_result.buzzer  = (r_band == BAND_STEADY);
        n_result.done    = 1'b0;

        case (eff_phase)
            PH_TRIG_LOW: begin
                n_timer = expired ? '0 : timer_inc;
                if (expired) n_phase = PH_TRIG_HIGH;
            end
            PH_TRIG_HIGH: begin
                n_result.trigger = 1'b1;
                n_timer = expired ? '0 : timer_inc;
                if (expired) n_phase = PH_WAIT_RISE;
            end
            PH_WAIT_RISE: begin
                if (i_echo_level) begin
                    n_width = WIDTH_BITS'(1);
                    n_timer = '0;
                    n_phase = PH_MEASURE;
                end else if (expired) begin
                    n_result.done = 1'b1;
                    n_timer  = '0;
                    n_phase  = fin_phase;
                    n_dist   = fin_dist;
                    n_status = fin_status;
                    n_band   = fin_band;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_MEASURE: begin
                if (i_echo_level && r_width < i_cfg.echo_limit) begin
                    if (r_width < WIDTH_MAX) n_width = r_width + 1'b1;
                end else begin
                    n_result.done = 1'b1;
                    n_timer  = '0;
                    n_phase  = fin_phase;
                    n_dist   = fin_dist;
                    n_status = fin_status;
                    n_band   = fin_band;
                end
            end
            PH_BLINK_ON: begin
                n_result.buzzer = 1'b1;
                n_timer = expired ? '0 : timer_inc;
                if (expired) n_phase = PH_BLINK_OFF;
            end
            PH_BLINK_OFF: begin
                n_result.buzzer = 1'b0;
                n_timer = expired ? '0 : timer_inc;
                if (expired) n_phase = after_buzz;
            end
            default: begin
                n_timer = expired ? '0 : timer_inc;
                if (expired) n_phase = PH_TRIG_LOW;
            end
        endcase

        n_result.status   = n_status;
        n_result.distance = n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TRIG_LOW;
            r_timer  <= '0;
            r_width  <= '0;
            r_dist   <= '0;
            r_status <= STAT_OK;
            r_band   <= BAND_OFF;
            r_result <= '0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_width  <= n_width;
            r_dist   <= n_dist;
            r_status <= n_status;
            r_band   <= n_band;
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

>>> src/ultrasonic_range_buzzer_top.sv
// Top level of the ultrasonic range buzzer: tick channel handshake, configuration
// registers and output valid. Depends on urb_pkg and urb_core.
//
// Usage:
// - Input channel: one transaction per microsecond tick carries the sampled echo
//   pin level (i_echo_level). It is taken when i_in_valid is high and o_in_stall
//   is low.
// - Output channel: every tick transaction produces exactly one result transaction
//   with trigger level, buzzer level, measure_done pulse, last status and last
//   distance; taken when o_out_valid is high and i_out_stall is low.
// - o_out_valid rises in the cycle after input acceptance; one tick per cycle
//   unless stalled, set by the single result register behind the sequencer.
// - When a valid result is stalled, the register holds and o_in_stall rises, so
//   at most one result is buffered; nothing is dropped.
// - Configuration port: i_cfg_valid / o_cfg_ready with register index and data.
//   o_cfg_ready is always high; write only while no tick is in flight.
// - Reset (i_rst_n low, synchronous) loads the default limits and periods,
//   empties the result register and starts a fresh trigger low phase.
module ultrasonic_range_buzzer_top #(
    parameter int TIMER_BITS         = 20,
    parameter int TRIGGER_HIGH_TICKS = 10,
    parameter int TRIGGER_LOW_TICKS  = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_echo_level,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_trigger_out,
    output logic                                o_buzzer_out,
    output logic                                o_measure_done,
    output logic [1:0]                          o_range_status,
    output logic [urb_pkg::DIST_BITS-1:0]       o_distance_cm,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [urb_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [urb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import urb_pkg::*;

    t_cfg    r_cfg;
    t_result core_result;
    logic    r_out_valid;
    logic    in_accept;

    // Take a new tick whenever the result slot is empty or being drained.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers, each masked to its own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.far_limit    <= RST_FAR_LIMIT;
            r_cfg.mid_limit    <= RST_MID_LIMIT;
            r_cfg.near_limit   <= RST_NEAR_LIMIT;
            r_cfg.slow_half    <= RST_SLOW_HALF;
            r_cfg.fast_half    <= RST_FAST_HALF;
            r_cfg.rise_timeout <= RST_RISE_TIMEOUT;
            r_cfg.echo_limit   <= RST_ECHO_LIMIT;
            r_cfg.cycle_gap    <= RST_CYCLE_GAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FAR_LIMIT:    r_cfg.far_limit    <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_MID_LIMIT:    r_cfg.mid_limit    <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_NEAR_LIMIT:   r_cfg.near_limit   <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_SLOW_HALF:    r_cfg.slow_half    <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_FAST_HALF:    r_cfg.fast_half    <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_RISE_TIMEOUT: r_cfg.rise_timeout <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_ECHO_LIMIT:   r_cfg.echo_limit   <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_CYCLE_GAP:    r_cfg.cycle_gap    <= i_cfg_data[PERIOD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Hold valid while stalled, drop it once drained with nothing new behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    urb_core #(
        .TIMER_BITS         (TIMER_BITS),
        .TRIGGER_HIGH_TICKS (TRIGGER_HIGH_TICKS),
        .TRIGGER_LOW_TICKS  (TRIGGER_LOW_TICKS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (in_accept),
        .i_echo_level (i_echo_level),
        .i_cfg        (r_cfg),
        .o_result     (core_result)
    );

    assign o_out_valid    = r_out_valid;
    assign o_trigger_out  = core_result.trigger;
    assign o_buzzer_out   = core_result.buzzer;
    assign o_measure_done = core_result.done;
    assign o_range_status = core_result.status;
    assign o_distance_cm  = core_result.distance;

endmodule

>>> src/urb_checker.sv
// Port-level checker for the ultrasonic range buzzer, bound to the top level.
// Depends on urb_pkg and ultrasonic_range_buzzer_top.
module urb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_trigger_out,
    input logic                          o_measure_done,
    input logic [1:0]                    o_range_status,
    input logic [urb_pkg::DIST_BITS-1:0] o_distance_cm
);
    import urb_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_distance_cm)
            && $stable(o_range_status) && $stable(o_measure_done))
        else $error("stalled result changed");

    // drained slot with no new tick empties
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !(i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result repeated after drain");

    // failed measurements report the saturated distance
    a_fail_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_range_status == STAT_TIMEOUT || o_range_status == STAT_NO_OBSTACLE)
            |-> o_distance_cm == DIST_MAX)
        else $error("failed measurement without saturated distance");

    // measurement never ends while the trigger is driven
    a_done_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_measure_done |-> !o_trigger_out)
        else $error("measurement done during trigger pulse");

endmodule

bind ultrasonic_range_buzzer_top urb_checker u_urb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_trigger_out  (o_trigger_out),
    .o_measure_done (o_measure_done),
    .o_range_status (o_range_status),
    .o_distance_cm  (o_distance_cm)
);
